// ----- rtl/usc_pkg.sv -----
// Shared types and constants of the URL syntax checker.
// No dependencies; every module imports this package.
package usc_pkg;

    localparam int MAX_LEN = 2048;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int ACC_W   = 17;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_PROTOCOL = 3'd1;
    localparam logic [2:0] ERR_DOMAIN   = 3'd2;
    localparam logic [2:0] ERR_SPACE    = 3'd3;
    localparam logic [2:0] ERR_PORT     = 3'd4;
    localparam logic [2:0] ERR_LONG     = 3'd5;

    // input register contents
    typedef struct packed {
        logic       valid;
        logic       cmd;
        logic [7:0] ch;
    } usc_stage_t;

    // parser state seen by the verdict logic
    typedef struct packed {
        logic             overlong;
        logic             scheme_failed;
        logic             in_scheme;
        logic             secure;
        logic             dot_seen;
        logic             localhost_match;
        logic [POS_W-1:0] host_count;
        logic             space_seen;
        logic             colon_seen;
        logic [ACC_W-1:0] port_accum;
        logic             port_nondigit;
        logic             slash_seen;
        logic [POS_W-1:0] slash_offset;
    } usc_parse_t;

endpackage

// ----- rtl/usc_in_if.sv -----
// Input channel of the URL syntax checker: one URL byte or end marker per word.
// Depends on nothing.
interface usc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] ch;

    modport source (output valid, output cmd, output ch, input ready);
    modport sink (input valid, input cmd, input ch, output ready);
endinterface

// ----- rtl/usc_out_if.sv -----
// Result channel of the URL syntax checker: one verdict per word.
// Depends on nothing.
interface usc_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [2:0]  error_code;
    logic        secure;
    logic        has_port;
    logic [15:0] port;
    logic [11:0] host_length;
    logic [10:0] path_start;
    logic        path_default;

    modport source (output valid, output valid_res, output error_code, output secure,
                    output has_port, output port, output host_length, output path_start,
                    output path_default, input ready);
    modport sink (input valid, input valid_res, input error_code, input secure,
                  input has_port, input port, input host_length, input path_start,
                  input path_default, output ready);
endinterface

// ----- rtl/usc_in_stage.sv -----
// Input register of the URL syntax checker.
// Depends on usc_pkg and usc_in_if.
module usc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    usc_in_if.sink            din,
    input  logic              drain,
    output usc_pkg::usc_stage_t stage
);
    import usc_pkg::*;

    logic       valid_reg;
    logic       cmd_reg;
    logic [7:0] ch_reg;
    logic       take;

    assign din.ready = !valid_reg || drain;
    assign take      = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= din.cmd;
            ch_reg  <= din.ch;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.cmd   = cmd_reg;
    assign stage.ch    = ch_reg;

endmodule

// ----- rtl/usc_parser.sv -----
// Per-byte parse state of the URL syntax checker: scheme, host, port and path tracking.
// Depends on usc_pkg.
module usc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_fire,
    input  logic                clear,
    input  logic [7:0]          ch,
    output usc_pkg::usc_parse_t pstate
);
    import usc_pkg::*;

    localparam logic [1:0] PH_SCHEME = 2'd0;
    localparam logic [1:0] PH_HOST   = 2'd1;
    localparam logic [1:0] PH_PORT   = 2'd2;
    localparam logic [1:0] PH_PATH   = 2'd3;

    localparam logic [3:0] IDX_S      = 4'd4;
    localparam logic [3:0] IDX_SLASH1 = 4'd6;
    localparam logic [3:0] PFX_LEN    = 4'd8;
    localparam logic [POS_W-1:0] LH_LEN = POS_W'(9);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(65536);

    function automatic logic [7:0] pfx_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "h";
            3'd1:    c = "t";
            3'd2:    c = "t";
            3'd3:    c = "p";
            3'd4:    c = "s";
            3'd5:    c = ":";
            default: c = "/";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lh_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "l";
            4'd1:    c = "o";
            4'd2:    c = "c";
            4'd3:    c = "a";
            4'd4:    c = "l";
            4'd5:    c = "h";
            4'd6:    c = "o";
            4'd7:    c = "s";
            default: c = "t";
        endcase
        return c;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       pfx_idx_reg, pfx_idx_next;
    logic             secure_reg, secure_next;
    logic             scheme_failed_reg, scheme_failed_next;
    logic [POS_W-1:0] host_count_reg, host_count_next;
    logic             dot_reg, dot_next;
    logic             lh_match_reg, lh_match_next;
    logic             colon_reg, colon_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             nondigit_reg, nondigit_next;
    logic [POS_W-1:0] slash_off_reg, slash_off_next;
    logic             slash_reg, slash_next;
    logic             space_reg, space_next;
    logic             overlong_reg, overlong_next;

    logic [19:0]      acc_ext;
    logic [19:0]      acc_mul;
    logic             is_digit;

    assign acc_ext  = 20'(acc_reg);
    assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + 20'(ch - CH_ZERO);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

    always_comb
    begin
        pos_next           = pos_reg;
        phase_next         = phase_reg;
        pfx_idx_next       = pfx_idx_reg;
        secure_next        = secure_reg;
        scheme_failed_next = scheme_failed_reg;
        host_count_next    = host_count_reg;
        dot_next           = dot_reg;
        lh_match_next      = lh_match_reg;
        colon_next         = colon_reg;
        acc_next           = acc_reg;
        nondigit_next      = nondigit_reg;
        slash_off_next     = slash_off_reg;
        slash_next         = slash_reg;
        space_next         = space_reg;
        overlong_next      = overlong_reg;

        if (clear)
        begin
            pos_next           = '0;
            phase_next         = PH_SCHEME;
            pfx_idx_next       = '0;
            secure_next        = 1'b0;
            scheme_failed_next = 1'b0;
            host_count_next    = '0;
            dot_next           = 1'b0;
            lh_match_next      = 1'b1;
            colon_next         = 1'b0;
            acc_next           = '0;
            nondigit_next      = 1'b0;
            slash_off_next     = '0;
            slash_next         = 1'b0;
            space_next         = 1'b0;
            overlong_next      = 1'b0;
        end
        else if (byte_fire && !overlong_reg)
        begin
            if (pos_reg >= POS_W'(MAX_LEN))
            begin
                overlong_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (ch == CH_SPACE)
                begin
                    space_next = 1'b1;
                end
                unique case (phase_reg)
                    PH_SCHEME:
                    begin
                        if (!scheme_failed_reg)
                        begin
                            // "https" and "http" share the prefix; ':' after "http" skips 's'
                            if (pfx_idx_reg == IDX_S && ch == CH_COLON)
                            begin
                                pfx_idx_next = IDX_SLASH1;
                            end
                            else if (pfx_idx_reg < PFX_LEN && ch == pfx_char(pfx_idx_reg[2:0]))
                            begin
                                if (pfx_idx_reg == IDX_S)
                                begin
                                    secure_next = 1'b1;
                                end
                                pfx_idx_next = pfx_idx_reg + 4'd1;
                                if (pfx_idx_reg + 4'd1 == PFX_LEN)
                                begin
                                    phase_next = PH_HOST;
                                end
                            end
                            else
                            begin
                                scheme_failed_next = 1'b1;
                            end
                        end
                    end
                    PH_HOST:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            slash_next     = 1'b1;
                            slash_off_next = pos_reg;
                            phase_next     = PH_PATH;
                        end
                        else if (ch == CH_COLON)
                        begin
                            colon_next = 1'b1;
                            phase_next = PH_PORT;
                        end
                        else
                        begin
                            if (ch == CH_DOT)
                            begin
                                dot_next = 1'b1;
                            end
                            if (host_count_reg >= LH_LEN || ch != lh_char(host_count_reg[3:0]))
                            begin
                                lh_match_next = 1'b0;
                            end
                            if (host_count_reg < POS_W'(MAX_LEN))
                            begin
                                host_count_next = host_count_reg + POS_W'(1);
                            end
                        end
                    end
                    PH_PORT:
                    begin
                        if (ch == CH_SLASH)
                        begin
                            slash_next     = 1'b1;
                            slash_off_next = pos_reg;
                            phase_next     = PH_PATH;
                        end
                        else if (is_digit)
                        begin
                            if (acc_mul > 20'(ACC_SAT))
                            begin
                                acc_next = ACC_SAT;
                            end
                            else
                            begin
                                acc_next = acc_mul[ACC_W-1:0];
                            end
                        end
                        else
                        begin
                            nondigit_next = 1'b1;
                        end
                    end
                    PH_PATH:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            phase_reg         <= PH_SCHEME;
            pfx_idx_reg       <= '0;
            secure_reg        <= 1'b0;
            scheme_failed_reg <= 1'b0;
            host_count_reg    <= '0;
            dot_reg           <= 1'b0;
            lh_match_reg      <= 1'b1;
            colon_reg         <= 1'b0;
            acc_reg           <= '0;
            nondigit_reg      <= 1'b0;
            slash_off_reg     <= '0;
            slash_reg         <= 1'b0;
            space_reg         <= 1'b0;
            overlong_reg      <= 1'b0;
        end
        else
        begin
            pos_reg           <= pos_next;
            phase_reg         <= phase_next;
            pfx_idx_reg       <= pfx_idx_next;
            secure_reg        <= secure_next;
            scheme_failed_reg <= scheme_failed_next;
            host_count_reg    <= host_count_next;
            dot_reg           <= dot_next;
            lh_match_reg      <= lh_match_next;
            colon_reg         <= colon_next;
            acc_reg           <= acc_next;
            nondigit_reg      <= nondigit_next;
            slash_off_reg     <= slash_off_next;
            slash_reg         <= slash_next;
            space_reg         <= space_next;
            overlong_reg      <= overlong_next;
        end
    end

    assign pstate.overlong        = overlong_reg;
    assign pstate.scheme_failed   = scheme_failed_reg;
    assign pstate.in_scheme       = (phase_reg == PH_SCHEME);
    assign pstate.secure          = secure_reg;
    assign pstate.dot_seen        = dot_reg;
    assign pstate.localhost_match = lh_match_reg;
    assign pstate.host_count      = host_count_reg;
    assign pstate.space_seen      = space_reg;
    assign pstate.colon_seen      = colon_reg;
    assign pstate.port_accum      = acc_reg;
    assign pstate.port_nondigit   = nondigit_reg;
    assign pstate.slash_seen      = slash_reg;
    assign pstate.slash_offset    = slash_off_reg;

    a_overlong_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        overlong_reg |-> pos_reg == POS_W'(MAX_LEN))
        else $error("overlong set before the length limit");

    a_past_scheme_full_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_SCHEME |-> pfx_idx_reg == PFX_LEN && !scheme_failed_reg)
        else $error("left scheme phase without a full prefix");

    a_host_within_pos: assert property (@(posedge clk) disable iff (!rst_n)
        host_count_reg <= pos_reg)
        else $error("host count exceeds bytes taken");

    a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> pos_reg == '0 && phase_reg == PH_SCHEME && !overlong_reg)
        else $error("state not cleared after verdict");

endmodule

// ----- rtl/usc_verdict.sv -----
// Verdict logic and result register of the URL syntax checker.
// Depends on usc_pkg and usc_out_if.
module usc_verdict (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  usc_pkg::usc_parse_t pstate,
    output logic                busy,
    usc_out_if.source           dout
);
    import usc_pkg::*;

    localparam logic [ACC_W-1:0] PORT_MAX = ACC_W'(65535);
    localparam logic [POS_W-1:0] LH_LEN   = POS_W'(9);

    logic        valid_reg;
    logic        ok_reg;
    logic [2:0]  err_reg;
    logic        secure_reg;
    logic        has_port_reg;
    logic [15:0] port_reg;
    logic [11:0] host_len_reg;
    logic [10:0] path_start_reg;
    logic        path_def_reg;

    logic        port_bad;
    logic        host_ok;
    logic [2:0]  err_next;
    logic        ok_next;

    assign port_bad = pstate.colon_seen && (pstate.port_nondigit
                      || pstate.port_accum == '0 || pstate.port_accum > PORT_MAX);
    assign host_ok  = pstate.dot_seen || (pstate.localhost_match && pstate.host_count == LH_LEN);

    always_comb
    begin
        if (pstate.overlong)
        begin
            err_next = ERR_LONG;
        end
        else if (pstate.scheme_failed || pstate.in_scheme)
        begin
            err_next = ERR_PROTOCOL;
        end
        else if (!host_ok)
        begin
            err_next = ERR_DOMAIN;
        end
        else if (pstate.space_seen)
        begin
            err_next = ERR_SPACE;
        end
        else if (port_bad)
        begin
            err_next = ERR_PORT;
        end
        else
        begin
            err_next = ERR_OK;
        end
    end

    assign ok_next = (err_next == ERR_OK);
    assign busy    = valid_reg && !dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // failed verdicts report all detail fields as zero
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg         <= ok_next;
            err_reg        <= err_next;
            secure_reg     <= ok_next && pstate.secure;
            has_port_reg   <= ok_next && pstate.colon_seen;
            port_reg       <= (ok_next && pstate.colon_seen) ? pstate.port_accum[15:0] : 16'd0;
            host_len_reg   <= ok_next ? 12'(pstate.host_count) : 12'd0;
            path_start_reg <= (ok_next && pstate.slash_seen) ? 11'(pstate.slash_offset) : 11'd0;
            path_def_reg   <= ok_next && !pstate.slash_seen;
        end
    end

    assign dout.valid        = valid_reg;
    assign dout.valid_res    = ok_reg;
    assign dout.error_code   = err_reg;
    assign dout.secure       = secure_reg;
    assign dout.has_port     = has_port_reg;
    assign dout.port         = port_reg;
    assign dout.host_length  = host_len_reg;
    assign dout.path_start   = path_start_reg;
    assign dout.path_default = path_def_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("result register loaded while a word waits");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ok_reg |-> port_reg == 16'd0 && host_len_reg == 12'd0
                                 && !secure_reg && !path_def_reg)
        else $error("failed verdict carries detail fields");

endmodule

// ----- rtl/url_syntax_checker_top.sv -----
// URL syntax checker top level: input register, parser state, verdict register.
// Depends on usc_pkg, usc_in_if, usc_out_if, usc_in_stage, usc_parser, usc_verdict.
//
// Usage: din carries one word per URL byte (cmd = 0, byte in ch) and then one
// end word (cmd = 1). For every end word one verdict word leaves on dout with
// the error code, the scheme flag, port, host length and path offset; byte
// words produce nothing. Both channels use a valid/ready handshake.
// Throughput: one word per cycle on din, bytes and end words alike, unless an end word
// stalls (see Stall); the per-byte update is one pass of compare and multiply-by-ten
// logic between the input register and the parse state registers.
// Verdict path: a taken end word sits in the input register until the result register is
// free; then the verdict logic on the parse state is loaded into the result register.
// Reset: rst_n clears the input register, the parse state and the result valid;
// the block is ready for the first byte of a URL right after reset.
// Stall: while a verdict waits on dout, byte words keep flowing into the parser;
// only a following end word waits in the input register until the result
// register frees, and din.ready stays low while it waits.
// Bytes past 2048 in one URL are dropped and the verdict reports "too long".
module url_syntax_checker_top (
    input logic       clk,
    input logic       rst_n,
    usc_in_if.sink    din,
    usc_out_if.source dout
);
    import usc_pkg::*;

    usc_stage_t stage;
    usc_parse_t pstate;
    logic       busy;
    logic       byte_fire;
    logic       verdict_fire;
    logic       drain;

    assign byte_fire    = stage.valid && !stage.cmd;
    assign verdict_fire = stage.valid && stage.cmd && !busy;
    assign drain        = byte_fire || verdict_fire;

    usc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .drain (drain),
        .stage (stage)
    );

    usc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .clear     (verdict_fire),
        .ch        (stage.ch),
        .pstate    (pstate)
    );

    usc_verdict u_verdict (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (verdict_fire),
        .pstate (pstate),
        .busy   (busy),
        .dout   (dout)
    );

endmodule
